FILE: design/fvtp_pkg.sv
package fvtp_pkg;

    // parse phases
    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_SEEK    = 5'd1,
        PH_PKTTYPE = 5'd2,
        PH_CTIME   = 5'd3,
        PH_VERSION = 5'd4,
        PH_PROFILE = 5'd5,
        PH_COMPAT  = 5'd6,
        PH_LEVEL   = 5'd7,
        PH_LENSIZE = 5'd8,
        PH_NSPS    = 5'd9,
        PH_SPSLEN  = 5'd10,
        PH_SPSBODY = 5'd11,
        PH_NPPS    = 5'd12,
        PH_PPSLEN  = 5'd13,
        PH_PPSBODY = 5'd14,
        PH_NALPFX  = 5'd15,
        PH_NALHDR  = 5'd16,
        PH_REST    = 5'd17
    } t_phase;

    // token kinds
    typedef enum logic [4:0] {
        K_FRAME    = 5'd0,
        K_CODEC    = 5'd1,
        K_SEEK     = 5'd2,
        K_PKTTYPE  = 5'd3,
        K_CTIME    = 5'd4,
        K_VERSION  = 5'd5,
        K_PROFILE  = 5'd6,
        K_COMPAT   = 5'd7,
        K_LEVEL    = 5'd8,
        K_LENSIZE  = 5'd9,
        K_NSPS     = 5'd10,
        K_SPSLEN   = 5'd11,
        K_NPPS     = 5'd12,
        K_PPSLEN   = 5'd13,
        K_FORBID   = 5'd14,
        K_NRI      = 5'd15,
        K_NALUTYPE = 5'd16,
        K_TAGEND   = 5'd17
    } t_kind;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_PKTTYPE = 3'd1,
        ERR_CTIME   = 3'd2,
        ERR_VERSION = 3'd3,
        ERR_RES6    = 3'd4,
        ERR_RES3    = 3'd5,
        ERR_TRUNC   = 3'd6
    } t_err;

    localparam int MAX_TOKENS = 4;
    localparam int CNT_W      = $clog2(MAX_TOKENS + 1);

    localparam logic [3:0] FRAME_INFO     = 4'd5;
    localparam logic [3:0] CODEC_AVC      = 4'd7;
    localparam logic [1:0] PKT_SEQ_HDR    = 2'd0;
    localparam logic [1:0] PKT_NALU       = 2'd1;
    localparam logic [7:0] PKT_MAX        = 8'd2;
    localparam logic [7:0] CFG_VERSION    = 8'd1;
    localparam logic [7:0] MASK_RES6      = 8'hfc;
    localparam logic [7:0] MASK_RES3      = 8'he0;

    typedef struct packed {
        t_phase        phase;
        logic [23:0]   tag_left;
        logic [1:0]    mbi;
        logic [23:0]   acc;
        logic [7:0]    psl;
        logic [15:0]   skip;
        logic [1:0]    lsm1;
        logic [1:0]    pkind;
        t_err          ferr;
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] value;
        t_err        err;
        logic        last;
    } t_token;

    function automatic t_token f_tok(t_kind kind, logic [23:0] value);
        t_token t;
        t.kind  = kind;
        t.value = value;
        t.err   = ERR_NONE;
        t.last  = 1'b0;
        return t;
    endfunction

endpackage

FILE: design/fvtp_in_if.sv
interface fvtp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        tag_start;
    logic [23:0] tag_size;

    modport source (output valid, data_byte, tag_start, tag_size, input ready);
    modport sink   (input valid, data_byte, tag_start, tag_size, output ready);
endinterface

FILE: design/fvtp_out_if.sv
interface fvtp_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_kind;
    logic [23:0] field_value;
    logic [2:0]  error_code;
    logic        last_of_tag;

    modport source (output valid, field_kind, field_value, error_code, last_of_tag,
                    input ready);
    modport sink   (input valid, field_kind, field_value, error_code, last_of_tag,
                    output ready);
endinterface

FILE: design/fvtp_step.sv
module fvtp_step
    import fvtp_pkg::*;
(
    input  t_state              i_state,
    input  logic [7:0]          i_byte,
    input  logic                i_tag_start,
    input  logic [23:0]         i_tag_size,
    output t_state              o_state,
    output t_token [MAX_TOKENS-1:0] o_tokens,
    output logic [CNT_W-1:0]    o_count
);

    // tag_end token, truncation if the tag stopped short of the rest phase
    function automatic t_token f_close(t_state st);
        t_token t;
        t = f_tok(K_TAGEND, 24'd0);
        t.err  = (st.ferr == ERR_NONE && st.phase != PH_REST) ? ERR_TRUNC : st.ferr;
        t.last = 1'b1;
        return t;
    endfunction

    function automatic t_state f_fail(t_state st, t_err code);
        t_state r;
        r = st;
        if (r.ferr == ERR_NONE) begin
            r.ferr = code;
        end
        r.phase = PH_REST;
        return r;
    endfunction

    // one parameter set done
    function automatic t_state f_finish(t_state st, logic sps);
        t_state r;
        r = st;
        r.psl = st.psl - 8'd1;
        r.mbi = '0;
        r.acc = '0;
        if (r.psl != '0) begin
            r.phase = sps ? PH_SPSLEN : PH_PPSLEN;
        end else begin
            r.phase = sps ? PH_NPPS : PH_REST;
        end
        return r;
    endfunction

    always_comb begin
        t_state                  s;
        t_token [MAX_TOKENS-1:0] t;
        logic [CNT_W-1:0]        k;
        logic                    live;
        logic                    sps;
        logic [7:0]              b;

        s    = i_state;
        t    = '0;
        k    = '0;
        live = 1'b1;
        b    = i_byte;
        sps  = 1'b0;

        if (i_tag_start) begin
            if (s.phase != PH_IDLE) begin
                t[k[1:0]] = f_close(s);
                k = k + 1'b1;
            end
            s.tag_left = (i_tag_size != '0) ? i_tag_size - 24'd1 : '0;
            s.mbi   = '0;
            s.acc   = '0;
            s.psl   = '0;
            s.skip  = '0;
            s.pkind = '0;
            s.ferr  = ERR_NONE;
            t[k[1:0]] = f_tok(K_FRAME, {20'd0, b[7:4]});
            k = k + 1'b1;
            t[k[1:0]] = f_tok(K_CODEC, {20'd0, b[3:0]});
            k = k + 1'b1;
            if (b[7:4] == FRAME_INFO) begin
                s.phase = PH_SEEK;
            end else if (b[3:0] == CODEC_AVC) begin
                s.phase = PH_PKTTYPE;
            end else begin
                s.phase = PH_REST;
            end
        end else if (s.phase == PH_IDLE) begin
            live = 1'b0;
        end else begin
            if (s.tag_left != '0) begin
                s.tag_left = s.tag_left - 24'd1;
            end
            case (i_state.phase)
                PH_SEEK: begin
                    t[k[1:0]] = f_tok(K_SEEK, {16'd0, b});
                    k = k + 1'b1;
                    s.phase = PH_REST;
                end
                PH_PKTTYPE: begin
                    if (b > PKT_MAX) begin
                        s = f_fail(s, ERR_PKTTYPE);
                    end else begin
                        s.pkind = b[1:0];
                        t[k[1:0]] = f_tok(K_PKTTYPE, {16'd0, b});
                        k = k + 1'b1;
                        s.mbi   = '0;
                        s.acc   = '0;
                        s.phase = PH_CTIME;
                    end
                end
                PH_CTIME: begin
                    s.acc = {s.acc[15:0], b};
                    s.mbi = s.mbi + 2'd1;
                    if (s.mbi == 2'd3) begin
                        if (s.pkind != PKT_NALU && s.acc != '0) begin
                            s = f_fail(s, ERR_CTIME);
                        end else begin
                            t[k[1:0]] = f_tok(K_CTIME, s.acc);
                            k = k + 1'b1;
                            s.mbi = '0;
                            if (s.pkind == PKT_SEQ_HDR) begin
                                s.phase = PH_VERSION;
                            end else if (s.pkind == PKT_NALU) begin
                                s.phase = PH_NALPFX;
                            end else begin
                                s.phase = PH_REST;
                            end
                        end
                    end
                end
                PH_VERSION: begin
                    if (b != CFG_VERSION) begin
                        s = f_fail(s, ERR_VERSION);
                    end else begin
                        t[k[1:0]] = f_tok(K_VERSION, {16'd0, b});
                        k = k + 1'b1;
                        s.phase = PH_PROFILE;
                    end
                end
                PH_PROFILE: begin
                    t[k[1:0]] = f_tok(K_PROFILE, {16'd0, b});
                    k = k + 1'b1;
                    s.phase = PH_COMPAT;
                end
                PH_COMPAT: begin
                    t[k[1:0]] = f_tok(K_COMPAT, {16'd0, b});
                    k = k + 1'b1;
                    s.phase = PH_LEVEL;
                end
                PH_LEVEL: begin
                    t[k[1:0]] = f_tok(K_LEVEL, {16'd0, b});
                    k = k + 1'b1;
                    s.phase = PH_LENSIZE;
                end
                PH_LENSIZE: begin
                    if ((b & MASK_RES6) != MASK_RES6) begin
                        s = f_fail(s, ERR_RES6);
                    end else begin
                        s.lsm1 = b[1:0];
                        t[k[1:0]] = f_tok(K_LENSIZE, {22'd0, b[1:0]});
                        k = k + 1'b1;
                        s.phase = PH_NSPS;
                    end
                end
                PH_NSPS: begin
                    if ((b & MASK_RES3) != MASK_RES3) begin
                        s = f_fail(s, ERR_RES3);
                    end else begin
                        s.psl = {3'd0, b[4:0]};
                        t[k[1:0]] = f_tok(K_NSPS, {19'd0, b[4:0]});
                        k = k + 1'b1;
                        s.mbi   = '0;
                        s.acc   = '0;
                        s.phase = (s.psl != '0) ? PH_SPSLEN : PH_NPPS;
                    end
                end
                PH_NPPS: begin
                    s.psl = b;
                    t[k[1:0]] = f_tok(K_NPPS, {16'd0, b});
                    k = k + 1'b1;
                    s.mbi   = '0;
                    s.acc   = '0;
                    s.phase = (s.psl != '0) ? PH_PPSLEN : PH_REST;
                end
                PH_SPSLEN, PH_PPSLEN: begin
                    sps   = (i_state.phase == PH_SPSLEN);
                    s.acc = {8'd0, s.acc[7:0], b};
                    s.mbi = s.mbi + 2'd1;
                    if (s.mbi == 2'd2) begin
                        t[k[1:0]] = f_tok(sps ? K_SPSLEN : K_PPSLEN, s.acc);
                        k = k + 1'b1;
                        s.skip = s.acc[15:0];
                        s.mbi  = '0;
                        if (s.skip != '0) begin
                            s.phase = sps ? PH_SPSBODY : PH_PPSBODY;
                        end else begin
                            s = f_finish(s, sps);
                        end
                    end
                end
                PH_SPSBODY, PH_PPSBODY: begin
                    sps    = (i_state.phase == PH_SPSBODY);
                    s.skip = s.skip - 16'd1;
                    if (s.skip == '0) begin
                        s = f_finish(s, sps);
                    end
                end
                PH_NALPFX: begin
                    if (s.mbi >= s.lsm1) begin
                        s.phase = PH_NALHDR;
                    end else begin
                        s.mbi = s.mbi + 2'd1;
                    end
                end
                PH_NALHDR: begin
                    t[k[1:0]] = f_tok(K_FORBID, {23'd0, b[7]});
                    k = k + 1'b1;
                    t[k[1:0]] = f_tok(K_NRI, {22'd0, b[6:5]});
                    k = k + 1'b1;
                    t[k[1:0]] = f_tok(K_NALUTYPE, {19'd0, b[4:0]});
                    k = k + 1'b1;
                    s.phase = PH_REST;
                end
                default: begin
                end
            endcase
        end

        if (live && s.tag_left == '0) begin
            t[k[1:0]] = f_close(s);
            k = k + 1'b1;
            s.phase = PH_IDLE;
        end

        o_state  = s;
        o_tokens = t;
        o_count  = k;
    end

endmodule

FILE: design/fvtp_tok_buf.sv
module fvtp_tok_buf
    import fvtp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [CNT_W-1:0]        i_count,
    input  t_token [MAX_TOKENS-1:0] i_tokens,
    output logic                    o_free,
    fvtp_out_if.source              o_out
);

    t_token [MAX_TOKENS-1:0] r_slot;
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        r_rd;
    t_token                  w_head;

    assign w_head      = r_slot[r_rd[$clog2(MAX_TOKENS)-1:0]];
    assign o_out.valid = (r_rd != r_cnt);
    assign o_out.field_kind  = w_head.kind;
    assign o_out.field_value = w_head.value;
    assign o_out.error_code  = w_head.err;
    assign o_out.last_of_tag = w_head.last;

    // empty now, or the last token leaves this cycle
    assign o_free = (r_rd == r_cnt) || ((r_rd + 1'b1 == r_cnt) && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (i_load) begin
            r_cnt <= i_count;
            r_rd  <= '0;
        end else if (o_out.valid && o_out.ready) begin
            r_rd <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_tokens;
        end
    end

`ifndef ASSERT_OFF
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd <= r_cnt && r_cnt <= CNT_W'(MAX_TOKENS))
        else $error("token read pointer past fill count");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("token buffer overwritten before drained");
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (i_count != '0 && i_count <= CNT_W'(MAX_TOKENS)))
        else $error("bad token count on load");
    a_load_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_rd == '0 && r_cnt == $past(i_count) && o_out.valid))
        else $error("loaded tokens not presented");
`endif

endmodule

FILE: design/flv_video_tag_parser.sv
// FLV AVC video tag parser: takes one payload byte per input transfer (tag_start
// and tag_size on the first byte of each tag) and delivers typed field tokens,
// one per output transfer, closing every tag with a tag_end token that carries
// the first error or a truncation. An input byte sits in an input register; the
// parse step for it is one pass of combinational logic that updates the parser
// state and fills a four-slot token buffer, which drains one token per cycle
// while the output is ready. A byte with no token or one token is taken as soon
// as the buffer is free, so such bytes flow back to back; a byte that gives k
// tokens (at most four: tag restart plus frame, codec and a closing tag_end, or
// the three NALU header fields plus tag_end) holds the input until they drain.
// The next byte is taken while the last token of the previous one is still
// waiting. No reset sweep; the block is ready right after reset, with a
// four-byte NALU length prefix assumed until a decoder config record is seen.
module flv_video_tag_parser
    import fvtp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    fvtp_in_if.sink    i_in,
    fvtp_out_if.source o_out
);

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_start;
    logic [23:0] r_in_size;

    // parser state
    t_state r_state;
    t_state n_state;

    t_token [MAX_TOKENS-1:0] w_tokens;
    logic [CNT_W-1:0]        w_count;
    logic                    w_free;
    logic                    w_take;

    // the held byte is parsed once its tokens have room
    assign w_take     = r_in_vld && ((w_count == '0) || w_free);
    assign i_in.ready = !r_in_vld || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (w_take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte  <= i_in.data_byte;
            r_in_start <= i_in.tag_start;
            r_in_size  <= i_in.tag_size;
        end
    end

    // state commits only when the byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= PH_IDLE;
            r_state.tag_left <= '0;
            r_state.mbi      <= '0;
            r_state.acc      <= '0;
            r_state.psl      <= '0;
            r_state.skip     <= '0;
            r_state.lsm1     <= 2'd3;
            r_state.pkind    <= '0;
            r_state.ferr     <= ERR_NONE;
        end else if (w_take) begin
            r_state <= n_state;
        end
    end

    fvtp_step u_step (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .i_tag_start (r_in_start),
        .i_tag_size  (r_in_size),
        .o_state     (n_state),
        .o_tokens    (w_tokens),
        .o_count     (w_count)
    );

    // token buffer and output port
    fvtp_tok_buf u_tok_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_take && (w_count != '0)),
        .i_count  (w_count),
        .i_tokens (w_tokens),
        .o_free   (w_free),
        .o_out    (o_out)
    );

endmodule
